>>> hdl/ste_pkg.sv
package ste_pkg;

  // table geometry
  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_INDEX  = 2'd2;
  localparam logic [1:0] CMD_REMOVE = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  // input beat
  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] value;
    logic [5:0]  position;
  } in_t;

  // result beat
  typedef struct packed {
    logic [31:0] read_value;
    logic [5:0]  found_position;
    logic [1:0]  status;
    logic [6:0]  entry_count;
  } out_t;

  // broadcast from the control to every cell
  typedef struct packed {
    logic   ins_en;
    logic   rem_en;
    value_t value;
    idx_t   rem_pos;
    idx_t   rd_pos;
    cnt_t   count;
  } ctl_t;

endpackage

>>> hdl/ste_cell.sv
module ste_cell (
  input  logic            clk,
  input  ste_pkg::idx_t   cell_idx,
  input  ste_pkg::ctl_t   ctl,
  input  ste_pkg::value_t left_entry,
  input  logic            left_lt,
  input  ste_pkg::value_t right_entry,
  output ste_pkg::value_t entry,
  output logic            lt,
  output logic            at_flag,
  output logic            hit,
  output ste_pkg::value_t rd_data
);
  import ste_pkg::*;

  value_t entry_r;
  value_t entry_nxt;
  logic   valid;

  // occupancy follows from the entry count
  assign valid = cnt_t'(cell_idx) < ctl.count;

  // compare against the broadcast value
  assign lt      = valid && (entry_r < ctl.value);
  assign at_flag = !lt && left_lt;
  assign hit     = valid && (entry_r == ctl.value) && left_lt;
  assign rd_data = (cell_idx == ctl.rd_pos) ? entry_r : '0;
  assign entry   = entry_r;

  // shift up on insert, down on remove
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins_en && !lt) begin
      entry_nxt = at_flag ? ctl.value : left_entry;
    end else if (ctl.rem_en && (cell_idx >= ctl.rem_pos)) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

>>> hdl/ste_sel.sv
module ste_sel (
  input  logic [ste_pkg::CAPACITY-1:0] at_vec,
  input  logic [ste_pkg::CAPACITY-1:0] hit_vec,
  input  ste_pkg::value_t              rd_data [ste_pkg::CAPACITY],
  output ste_pkg::idx_t                at_pos,
  output ste_pkg::idx_t                hit_pos,
  output logic                         hit_any,
  output ste_pkg::value_t              rd_entry
);
  import ste_pkg::*;

  // one-hot encode and or-combine over the row of cells
  always_comb begin
    at_pos   = '0;
    hit_pos  = '0;
    rd_entry = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (at_vec[i]) begin
        at_pos = at_pos | idx_t'(i);
      end
      if (hit_vec[i]) begin
        hit_pos = hit_pos | idx_t'(i);
      end
      rd_entry = rd_entry | rd_data[i];
    end
  end

  assign hit_any = |hit_vec;

endmodule

>>> hdl/sorted_table_engine_top.sv
// a result strobes on out_valid in the cycle after its command is taken
// throughput: one command per cycle, busy stays low; all cells compare and shift
// in parallel in the accepting cycle, so the next command sees the updated table
// reset: synchronous active-low rst_n empties the table (count zero) and drops
// out_valid; entry storage is not cleared; the receiver cannot stall
module sorted_table_engine_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  ste_pkg::in_t  in_data,
  output logic          out_valid,
  output ste_pkg::out_t out_data
);
  import ste_pkg::*;

  cnt_t   count_r;
  cnt_t   count_nxt;
  logic   out_valid_r;
  out_t   out_r;
  out_t   out_nxt;
  logic   accept;
  logic   full;
  logic   in_range;
  value_t val;
  ctl_t   ctl;

  value_t                entry_vec [CAPACITY];
  value_t                rd_vec    [CAPACITY];
  logic   [CAPACITY-1:0] lt_vec;
  logic   [CAPACITY-1:0] at_vec;
  logic   [CAPACITY-1:0] hit_vec;
  idx_t                  at_pos;
  idx_t                  hit_pos;
  logic                  hit_any;
  value_t                rd_entry;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign val    = value_t'(in_data.value);
  assign full   = (count_r == cnt_t'(CAPACITY));
  assign in_range = (32'(in_data.position) < 32'(count_r));

  // broadcast to the cells
  always_comb begin
    ctl.ins_en  = accept && (in_data.cmd == CMD_INSERT) && !full;
    ctl.rem_en  = accept && (in_data.cmd == CMD_REMOVE) && in_range;
    ctl.value   = val;
    ctl.rem_pos = idx_t'(in_data.position);
    ctl.rd_pos  = idx_t'(in_data.position);
    ctl.count   = count_r;
  end

  // row of cells, each linked to both neighbours
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    value_t left_e;
    value_t right_e;
    logic   left_l;
    if (g == 0) begin : g_first
      assign left_e = entry_vec[g];
      assign left_l = 1'b1;
    end else begin : g_mid
      assign left_e = entry_vec[g-1];
      assign left_l = lt_vec[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_e = entry_vec[g];
    end else begin : g_body
      assign right_e = entry_vec[g+1];
    end
    ste_cell u_cell (
      .clk         (clk),
      .cell_idx    (idx_t'(g)),
      .ctl         (ctl),
      .left_entry  (left_e),
      .left_lt     (left_l),
      .right_entry (right_e),
      .entry       (entry_vec[g]),
      .lt          (lt_vec[g]),
      .at_flag     (at_vec[g]),
      .hit         (hit_vec[g]),
      .rd_data     (rd_vec[g])
    );
  end

  ste_sel u_sel (
    .at_vec   (at_vec),
    .hit_vec  (hit_vec),
    .rd_data  (rd_vec),
    .at_pos   (at_pos),
    .hit_pos  (hit_pos),
    .hit_any  (hit_any),
    .rd_entry (rd_entry)
  );

  // count update and result beat
  always_comb begin
    count_nxt = count_r;
    if (ctl.ins_en) begin
      count_nxt = count_r + cnt_t'(1);
    end else if (ctl.rem_en) begin
      count_nxt = count_r - cnt_t'(1);
    end
    out_nxt.read_value     = '0;
    out_nxt.found_position = '0;
    out_nxt.status         = ST_OK;
    out_nxt.entry_count    = 7'(count_nxt);
    case (in_data.cmd)
      CMD_INSERT: begin
        if (full) begin
          out_nxt.status = ST_FULL;
        end else begin
          out_nxt.found_position = 6'(at_pos);
        end
      end
      CMD_LOOKUP: begin
        if (in_range) begin
          out_nxt.read_value = 32'(rd_entry);
        end else begin
          out_nxt.status = ST_RANGE;
        end
      end
      CMD_INDEX: begin
        if (hit_any) begin
          out_nxt.found_position = 6'(hit_pos);
        end else begin
          out_nxt.status = ST_NOTFOUND;
        end
      end
      CMD_REMOVE: begin
        if (!in_range) begin
          out_nxt.status = ST_RANGE;
        end
      end
      default: begin
        out_nxt.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= accept ? count_nxt : count_r;
      out_valid_r <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // sorted prefix gives exactly one insertion point while there is room
  a_one_insert_point: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r < cnt_t'(CAPACITY)) |-> $onehot(at_vec))
    else $error("insertion point not unique");

  // index-of never matches at two cells
  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("multiple first-match cells");

  // count stays within capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(CAPACITY))
    else $error("entry count above capacity");

  // a successful insert grows the table by one
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins_en |=> (count_r == $past(count_r) + cnt_t'(1)))
    else $error("insert did not grow the table");

  // a beat leaves for every accepted command
  a_result_beat: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted command without result beat");

endmodule

>>> test/ste_table_checker.sv
`timescale 1ns / 100ps

module ste_table_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  ste_pkg::in_t  in_data,
  input  logic          out_valid,
  input  ste_pkg::out_t out_data,
  output int            errors,
  output int            pending,
  output int            n_results,
  output int            n_full,
  output int            n_hits
);

  import ste_pkg::*;

  // shadow copy of the sorted table
  value_t table_vals [CAPACITY];
  int     table_len;

  out_t expected_results [$];
  int   fails;
  int   results_seen;
  int   full_seen;
  int   hits_seen;

  // apply one command to the shadow table and return the answer it gives
  function automatic out_t apply_to_table(in_t beat);
    out_t   ans;
    value_t key;
    int     slot;
    int     k;
    ans  = '0;
    key  = value_t'(beat.value);
    slot = 0;
    case (beat.cmd)
      CMD_INSERT: begin
        if (table_len >= CAPACITY) begin
          ans.status = ST_FULL;
        end else begin
          // goes ahead of any equal entries
          while (slot < table_len && table_vals[slot] < key) slot++;
          for (k = table_len; k > slot; k--) table_vals[k] = table_vals[k-1];
          table_vals[slot]   = key;
          table_len++;
          ans.found_position = 6'(slot);
          ans.status         = ST_OK;
        end
      end
      CMD_LOOKUP: begin
        if (int'(beat.position) >= table_len) begin
          ans.status = ST_RANGE;
        end else begin
          ans.read_value = 32'(table_vals[beat.position]);
          ans.status     = ST_OK;
        end
      end
      CMD_INDEX: begin
        ans.status = ST_NOTFOUND;
        for (k = 0; k < table_len; k++) begin
          if (table_vals[k] == key) begin
            ans.found_position = 6'(k);
            ans.status         = ST_OK;
            break;
          end
        end
      end
      default: begin
        // remove
        if (int'(beat.position) >= table_len) begin
          ans.status = ST_RANGE;
        end else begin
          for (k = int'(beat.position); k + 1 < table_len; k++) begin
            table_vals[k] = table_vals[k+1];
          end
          table_len--;
          ans.status = ST_OK;
        end
      end
    endcase
    ans.entry_count = 7'(table_len);
    return ans;
  endfunction

  function automatic void report(string fld, longint unsigned exp_v, longint unsigned act_v);
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fld, exp_v, act_v);
  endfunction

  initial begin
    table_len    = 0;
    fails        = 0;
    results_seen = 0;
    full_seen    = 0;
    hits_seen    = 0;
    errors       = 0;
    pending      = 0;
    n_results    = 0;
    n_full       = 0;
    n_hits       = 0;
  end

  // predict on each accepted command, compare each result beat
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      table_len = 0;
      expected_results.delete();
    end else begin
      if (start && !busy) begin
        want = apply_to_table(in_data);
        if (in_data.cmd == CMD_INDEX && want.status == ST_OK) hits_seen++;
        expected_results.push_back(want);
      end
      if (out_valid) begin
        results_seen++;
        if (out_data.status == ST_FULL) full_seen++;
        if (expected_results.size() == 0) begin
          fails++;
          $display("%0t: result beat with nothing expected, actual 0x%0h", $time, out_data);
        end else begin
          want = expected_results.pop_front();
          if (out_data.read_value != want.read_value) begin
            fails++;
            report("read_value", want.read_value, out_data.read_value);
          end
          if (out_data.found_position != want.found_position) begin
            fails++;
            report("found_position", want.found_position, out_data.found_position);
          end
          if (out_data.status != want.status) begin
            fails++;
            report("status", want.status, out_data.status);
          end
          if (out_data.entry_count != want.entry_count) begin
            fails++;
            report("entry_count", want.entry_count, out_data.entry_count);
          end
        end
      end
    end
    // exported counters settle after the edge so the stimulus side reads them cleanly
    errors    <= fails;
    pending   <= expected_results.size();
    n_results <= results_seen;
    n_full    <= full_seen;
    n_hits    <= hits_seen;
  end

endmodule

>>> test/tb_sorted_table_engine_top.sv
`timescale 1ns / 100ps

module tb_sorted_table_engine_top;

  import ste_pkg::*;

  // bounds a correct run of 2000 random commands plus the directed ones and idle gaps
  localparam int CYCLE_LIMIT = 200000;
  localparam int N_RANDOM    = 2000;

  typedef enum logic [1:0] {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;

  int errors;
  int pending;
  int n_results;
  int n_full;
  int n_hits;

  int     cycles;
  int     issued;
  int     fill_level;
  value_t recent [16];
  int     recent_wr;

  sorted_table_engine_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  ste_table_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .errors   (errors),
    .pending  (pending),
    .n_results(n_results),
    .n_full   (n_full),
    .n_hits   (n_hits)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // drive one command and hold it until taken
  task automatic issue(input logic [1:0] op, input logic [31:0] val, input logic [5:0] pos);
    in_t beat;
    beat.cmd      = op;
    beat.value    = val;
    beat.position = pos;
    start   <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (busy);
    issued++;
    // rough fill tracking, only used to steer positions
    if (op == CMD_INSERT && fill_level < CAPACITY) begin
      fill_level++;
      recent[recent_wr] = val;
      recent_wr = (recent_wr + 1) % 16;
    end else if (op == CMD_REMOVE && int'(pos) < fill_level) begin
      fill_level--;
    end
  endtask

  // idle gap with start low and noise on the data bus
  task automatic pause(input int n);
    start   <= 1'b0;
    in_data <= in_t'(40'({$urandom, $urandom}));
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value(input bit from_table);
    int r;
    r = $urandom_range(0, 99);
    if (from_table && r < 60) return recent[$urandom_range(0, 15)];
    if (r < 40) return recent[$urandom_range(0, 15)];
    if (r < 45) return 32'h0000_0000;
    if (r < 50) return 32'hFFFF_FFFF;
    if (r < 60) return 32'($urandom_range(0, 7));
    return $urandom;
  endfunction

  function automatic logic [5:0] pick_position();
    if (fill_level > 0 && $urandom_range(0, 99) < 80) return 6'($urandom_range(0, fill_level - 1));
    return 6'($urandom_range(0, 63));
  endfunction

  initial begin
    mix_t       mix;
    int         seg_left;
    int         burst_left;
    bit         no_gaps;
    int         r;
    logic [1:0] op;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_data    = '0;
    issued     = 0;
    fill_level = 0;
    recent_wr  = 0;
    foreach (recent[i]) recent[i] = $urandom;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extremes, equal values, both ends of the table
    issue(CMD_LOOKUP, 32'h0, 6'd0);
    issue(CMD_REMOVE, 32'h0, 6'd0);
    issue(CMD_INDEX,  32'h0, 6'd0);
    issue(CMD_INSERT, 32'hFFFF_FFFF, 6'd63);
    issue(CMD_INSERT, 32'h0000_0000, 6'd0);
    issue(CMD_INSERT, 32'h8000_0000, 6'd0);
    issue(CMD_INSERT, 32'h8000_0000, 6'd0);
    issue(CMD_INSERT, 32'h0000_0000, 6'd0);
    issue(CMD_LOOKUP, 32'h0, 6'd0);
    issue(CMD_LOOKUP, 32'h0, 6'd4);
    issue(CMD_LOOKUP, 32'h0, 6'd5);
    issue(CMD_LOOKUP, 32'h0, 6'd63);
    issue(CMD_INDEX,  32'h8000_0000, 6'd0);
    issue(CMD_INDEX,  32'hFFFF_FFFF, 6'd0);
    issue(CMD_INDEX,  32'h0000_0001, 6'd0);
    issue(CMD_REMOVE, 32'h0, 6'd4);
    issue(CMD_REMOVE, 32'h0, 6'd0);
    issue(CMD_REMOVE, 32'h0, 6'd63);
    issue(CMD_LOOKUP, 32'h0, 6'd2);
    issue(CMD_INDEX,  32'h0000_0000, 6'd0);
    pause(3);

    // random: segments that fill, drain or churn the table, sent in bursts
    seg_left   = 0;
    burst_left = 0;
    mix        = MIX_EVEN;
    no_gaps    = 1'b0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (seg_left == 0) begin
        r        = $urandom_range(0, 2);
        mix      = (r == 0) ? MIX_GROW : (r == 1) ? MIX_SHRINK : MIX_EVEN;
        seg_left = $urandom_range(40, 200);
        no_gaps  = ($urandom_range(0, 3) == 0);
      end
      seg_left--;
      r = $urandom_range(0, 99);
      case (mix)
        MIX_GROW:   op = (r < 70) ? CMD_INSERT : (r < 80) ? CMD_LOOKUP :
                         (r < 90) ? CMD_INDEX : CMD_REMOVE;
        MIX_SHRINK: op = (r < 15) ? CMD_INSERT : (r < 30) ? CMD_LOOKUP :
                         (r < 45) ? CMD_INDEX : CMD_REMOVE;
        default:    op = (r < 30) ? CMD_INSERT : (r < 55) ? CMD_LOOKUP :
                         (r < 80) ? CMD_INDEX : CMD_REMOVE;
      endcase
      issue(op, pick_value(op == CMD_INDEX), pick_position());
      // gap between bursts, skipped in segments without gaps
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        if (!no_gaps) pause($urandom_range(1, 6));
      end else begin
        burst_left--;
      end
    end
    pause(1);

    // drain, then let the pipeline settle
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("%0d commands sent, %0d results checked", issued, n_results);
    $display("table-full answers: %0d, index-of hits: %0d", n_full, n_hits);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/ste_pkg.sv
hdl/ste_cell.sv
hdl/ste_sel.sv
hdl/sorted_table_engine_top.sv
test/ste_table_checker.sv
test/tb_sorted_table_engine_top.sv
